[design/lscs_pkg.sv]
// Shared types and constants for the line whitespace-collapse and comment-strip block.
package lscs_pkg;

  // Saturation limit of the kept-byte count and the derived widths
  localparam int MAX_LINE = 4096;
  localparam int CNT_W    = $clog2(MAX_LINE + 1);
  localparam int LEN_W    = 13;
  localparam int BYTE_W   = 8;

  // Queue between front and back
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // Input word kinds (in_tuser)
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

  // All results caused by one input word: up to three bytes, then the length
  typedef struct packed {
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte2;
    logic [1:0]        n_bytes;
    logic              has_len;
    logic [LEN_W-1:0]  length;
  } bundle_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic is_ws(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

[design/lscs_front.sv]
// Front part: accepts input words, tracks line state and builds result bundles.
module lscs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_action,
  input  logic [7:0]        in_char,
  output logic              push,
  output lscs_pkg::bundle_t push_data
);

  logic                       started_r, started_nxt;
  logic                       space_pending_r, space_pending_nxt;
  logic                       slash_held_r, slash_held_nxt;
  logic                       comment_seen_r, comment_seen_nxt;
  logic [lscs_pkg::CNT_W-1:0] kept_count_r, kept_count_nxt;

  // Classify the word and work out the bytes it releases
  always_comb begin
    logic                       pre_sp;
    logic [1:0]                 m;
    logic [7:0]                 x;
    logic [7:0]                 y;
    logic [1:0]                 nb;
    logic                       end_line;
    logic [lscs_pkg::CNT_W:0]   sum;
    logic [lscs_pkg::CNT_W-1:0] cnt_sat;

    started_nxt       = started_r;
    space_pending_nxt = space_pending_r;
    slash_held_nxt    = slash_held_r;
    comment_seen_nxt  = comment_seen_r;
    pre_sp            = 1'b0;
    m                 = 2'd0;
    x                 = lscs_pkg::CH_NUL;
    y                 = lscs_pkg::CH_NUL;
    end_line          = 1'b0;
    push_data         = '0;

    if (in_fire) begin
      if (in_action == lscs_pkg::ACT_END) begin
        end_line = 1'b1;
        if (slash_held_r && !comment_seen_r) begin
          pre_sp = space_pending_r;
          m      = 2'd1;
          x      = lscs_pkg::CH_SLASH;
        end
      end else if ((in_char != lscs_pkg::CH_NUL) && !comment_seen_r) begin
        if (slash_held_r) begin
          slash_held_nxt = 1'b0;
          if (in_char == lscs_pkg::CH_SLASH) begin
            // Comment begins: drop the held slash and pending space
            comment_seen_nxt  = 1'b1;
            space_pending_nxt = 1'b0;
          end else if (lscs_pkg::is_ws(in_char)) begin
            pre_sp            = space_pending_r;
            m                 = 2'd1;
            x                 = lscs_pkg::CH_SLASH;
            space_pending_nxt = 1'b1;
          end else begin
            pre_sp            = space_pending_r;
            m                 = 2'd2;
            x                 = lscs_pkg::CH_SLASH;
            y                 = in_char;
            space_pending_nxt = 1'b0;
          end
        end else if (lscs_pkg::is_ws(in_char)) begin
          if (started_r) begin
            space_pending_nxt = 1'b1;
          end
        end else if (in_char == lscs_pkg::CH_SLASH) begin
          started_nxt    = 1'b1;
          slash_held_nxt = 1'b1;
        end else begin
          started_nxt       = 1'b1;
          pre_sp            = space_pending_r;
          m                 = 2'd1;
          x                 = in_char;
          space_pending_nxt = 1'b0;
        end
      end
    end

    // Place the bytes, with the collapsed space first when it goes out
    if (pre_sp) begin
      push_data.byte0 = lscs_pkg::CH_SPACE;
      push_data.byte1 = x;
      push_data.byte2 = y;
      nb              = m + 2'd1;
    end else begin
      push_data.byte0 = x;
      push_data.byte1 = y;
      push_data.byte2 = lscs_pkg::CH_NUL;
      nb              = m;
    end
    push_data.n_bytes = nb;

    // Advance the saturating kept count
    sum = {1'b0, kept_count_r} + (lscs_pkg::CNT_W + 1)'(nb);
    if (sum > (lscs_pkg::CNT_W + 1)'(lscs_pkg::MAX_LINE)) begin
      cnt_sat = lscs_pkg::CNT_W'(lscs_pkg::MAX_LINE);
    end else begin
      cnt_sat = sum[lscs_pkg::CNT_W-1:0];
    end
    kept_count_nxt = cnt_sat;

    // End of line: report the length and return to the reset state
    if (end_line) begin
      push_data.has_len = 1'b1;
      push_data.length  = lscs_pkg::LEN_W'(cnt_sat);
      started_nxt       = 1'b0;
      space_pending_nxt = 1'b0;
      slash_held_nxt    = 1'b0;
      comment_seen_nxt  = 1'b0;
      kept_count_nxt    = '0;
    end

    push = in_fire && ((nb != 2'd0) || end_line);
  end

  // Hold the line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r       <= 1'b0;
      space_pending_r <= 1'b0;
      slash_held_r    <= 1'b0;
      comment_seen_r  <= 1'b0;
      kept_count_r    <= '0;
    end else begin
      started_r       <= started_nxt;
      space_pending_r <= space_pending_nxt;
      slash_held_r    <= slash_held_nxt;
      comment_seen_r  <= comment_seen_nxt;
      kept_count_r    <= kept_count_nxt;
    end
  end

  // A held slash is released before a comment is marked
  a_slash_not_in_comment: assert property (@(posedge clk) disable iff (!rst_n)
    !(slash_held_r && comment_seen_r))
    else $error("slash held inside a comment");

  // Nothing is held or pending before the first non-blank byte
  a_idle_before_start: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> (!slash_held_r && !space_pending_r && kept_count_r == '0))
    else $error("line state set before start");

  // Kept count never passes the limit
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    kept_count_r <= lscs_pkg::CNT_W'(lscs_pkg::MAX_LINE))
    else $error("kept count beyond limit");

endmodule

[design/lscs_queue.sv]
// Short bundle queue between the front and back parts.
module lscs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lscs_pkg::bundle_t    push_data,
  input  logic                 pop,
  output lscs_pkg::bundle_t    head,
  output lscs_pkg::q_status_t status
);

  lscs_pkg::bundle_t           mem_r [lscs_pkg::QDEPTH];
  logic [lscs_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lscs_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lscs_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == lscs_pkg::QCNT_W'(lscs_pkg::QDEPTH));
  assign head         = mem_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + lscs_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + lscs_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + lscs_pkg::QCNT_W'(push) - lscs_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the bundle
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    status.full |-> !push)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    status.empty |-> !pop)
    else $error("pop from empty queue");

  a_level_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + lscs_pkg::QCNT_W'(1)))
    else $error("queue level lost a push");

endmodule

[design/lscs_back.sv]
// Back part: walks bundles, one result word per cycle unless stalled.
module lscs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lscs_pkg::bundle_t    head,
  input  lscs_pkg::q_status_t  status,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,
  output logic                 out_tuser,
  output logic                 out_tlast
);

  logic [1:0]                 idx_r, idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [lscs_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [lscs_pkg::LEN_W-1:0] out_len_r, out_len_nxt;
  logic                       out_is_len_r, out_is_len_nxt;
  logic                       out_last_r, out_last_nxt;

  // Pick the next result of the head bundle when the output slot frees
  always_comb begin
    logic       load;
    logic [1:0] total;
    logic       last;

    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_len_nxt    = out_len_r;
    out_is_len_nxt = out_is_len_r;
    out_last_nxt   = out_last_r;
    pop            = 1'b0;

    load  = !out_valid_r || out_tready;
    total = head.n_bytes + 2'(head.has_len);
    last  = (idx_r == total - 2'd1);

    if (load) begin
      if (status.empty) begin
        out_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = last;
        if (idx_r < head.n_bytes) begin
          out_is_len_nxt = 1'b0;
          out_len_nxt    = '0;
          unique case (idx_r)
            2'd0:    out_byte_nxt = head.byte0;
            2'd1:    out_byte_nxt = head.byte1;
            2'd2:    out_byte_nxt = head.byte2;
            default: out_byte_nxt = lscs_pkg::CH_NUL;
          endcase
        end else begin
          out_is_len_nxt = 1'b1;
          out_len_nxt    = head.length;
          out_byte_nxt   = lscs_pkg::CH_NUL;
        end
        if (last) begin
          pop     = 1'b1;
          idx_nxt = 2'd0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_len_r    <= out_len_nxt;
    out_is_len_r <= out_is_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_len_r, out_byte_r};
  assign out_tuser  = out_is_len_r;
  assign out_tlast  = out_last_r;

  // A length word always closes its input word
  a_len_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("length word not marked last");

  // Walk index rests at zero whenever the queue is empty
  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    status.empty |-> (idx_r == 2'd0))
    else $error("walk index left mid-bundle");

  // A stalled word is held
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled word changed");

endmodule

[design/line_space_collapse_comment_strip_top.sv]
// Top level of the line whitespace-collapse and comment-strip block.
//
//  channel | dir | tdata                        | tuser      | tlast
//  --------+-----+------------------------------+------------+------------
//  in_     | in  | [7:0] char_in                | action     | -
//  out_    | out | [7:0] out_byte, [20:8] length| is_length  | last_of_run
//
// One input word per cycle is taken while the four-entry bundle queue has room.
// The output stage sends one result word at a time; a word that releases
// two or three results holds the back part until all have gone out, and the queue
// absorbs that until it fills, then in_tready drops.
// Synchronous active-low reset clears line state, queue and output valid.
// Either side may stall on its own; the output register holds a word until taken.
module line_space_collapse_comment_strip_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [20:8] line_length, [23:21] zero
  output logic        out_tuser,  // [0] is_length
  output logic        out_tlast
);

  lscs_pkg::bundle_t   push_data;
  lscs_pkg::bundle_t   head;
  lscs_pkg::q_status_t status;
  logic                push;
  logic                pop;
  logic                in_fire;

  assign in_tready = !status.full;
  assign in_fire   = in_tvalid && in_tready;

  lscs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_action (in_tuser),
    .in_char   (in_tdata),
    .push      (push),
    .push_data (push_data)
  );

  lscs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  lscs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .status     (status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
